>>> rtl/che_pkg.sv
// Shared constants, status codes and pipeline context type for the cubic
// Hermite point evaluator. No dependencies.
`default_nettype none

package che_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // u lies in [0, 2^FRAC_BITS]
  localparam int U_W     = FRAC_BITS + 1;
  localparam int DIV_N   = FRAC_BITS + 1;
  localparam int H_W     = FRAC_BITS + 4;
  localparam int DP_W    = DATA_W + 1;
  localparam int P01_W   = DP_W + H_W;
  localparam int P1X_W   = DATA_W + 1 + H_W;
  localparam int T01_W   = P01_W - FRAC_BITS;
  localparam int PV_W    = 2 * DATA_W;
  localparam int PVS_W   = PV_W - FRAC_BITS;
  localparam int SUM_W   = PV_W - FRAC_BITS + 2;
  localparam int LATENCY = FRAC_BITS + 9;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CLAMPED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_SAT     = 2'd3
  } status_e;

  typedef struct packed {
    logic                     empty;
    logic                     clamp;
    logic signed [DATA_W-1:0] ps;
    logic signed [DP_W-1:0]   dp;
    logic signed [DATA_W-1:0] vs;
    logic signed [DATA_W-1:0] vf;
    logic [DATA_W-1:0]        dt;
  } ctx_t;

endpackage

`default_nettype wire

>>> rtl/cubic_hermite_point_eval_top.sv
// Cubic Hermite point evaluator, one axis per beat, fully pipelined.
// Depends on che_pkg.
//
// Usage:
//   Input beat: drive the seven segment fields and pulse start_i. A beat is
//   taken at every rising edge with start_i high and busy_o low; busy_o is
//   never raised, so a beat may be offered in every cycle.
//   Result beat: done_o is high for one cycle with position_o and status_o
//   valid; the receiver must take it in that cycle.
//   Throughput: one beat per cycle. The pipeline is one input register
//   stage, the restoring divider for u, one quotient bit per stage
//   (FRAC_BITS + 1 stages), then two squaring/cubing stages, one basis
//   stage, two multiply stages, one summing stage and one saturation stage.
//   Status: 0 ok, 1 time clamped, 2 empty segment, 3 saturated.
//   Reset: asynchronous, clears all stage valid bits; beats in flight are
//   dropped and no result is produced for them. No clearing pass.
`default_nettype none

module cubic_hermite_point_eval_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic signed [che_pkg::DATA_W-1:0]     pos_start_i,
  input  wire logic signed [che_pkg::DATA_W-1:0]     pos_end_i,
  input  wire logic signed [che_pkg::DATA_W-1:0]     vel_start_i,
  input  wire logic signed [che_pkg::DATA_W-1:0]     vel_end_i,
  input  wire logic        [che_pkg::DATA_W-1:0]     time_now_i,
  input  wire logic        [che_pkg::DATA_W-1:0]     time_start_i,
  input  wire logic        [che_pkg::DATA_W-1:0]     time_end_i,
  output logic                                       done_o,
  output logic signed [che_pkg::DATA_W-1:0]          position_o,
  output logic        [1:0]                          status_o
);

  localparam int F      = che_pkg::FRAC_BITS;
  localparam int DW     = che_pkg::DATA_W;
  localparam int UW     = che_pkg::U_W;
  localparam int DN     = che_pkg::DIV_N;
  localparam int HW     = che_pkg::H_W;
  localparam int SW     = che_pkg::SUM_W;
  localparam int LAT    = che_pkg::LATENCY;

  // ---------------------------------------------------------------- stage 0
  logic             s0_v_q;
  logic [DW-1:0]    s0_tau_q, s0_tau_d;
  che_pkg::ctx_t    s0_c_q, s0_c_d;
  logic             accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    logic [DW-1:0] dt;
    logic          before_s, after_e;
    dt       = time_end_i - time_start_i;
    before_s = time_now_i < time_start_i;
    after_e  = time_now_i > time_end_i;
    if (before_s) begin
      s0_tau_d = '0;
    end else if (after_e) begin
      s0_tau_d = dt;
    end else begin
      s0_tau_d = time_now_i - time_start_i;
    end
    s0_c_d.empty = time_end_i <= time_start_i;
    s0_c_d.clamp = before_s || after_e;
    s0_c_d.ps    = pos_start_i;
    s0_c_d.dp    = {pos_end_i[DW-1], pos_end_i} - {pos_start_i[DW-1], pos_start_i};
    s0_c_d.vs    = vel_start_i;
    s0_c_d.vf    = vel_end_i;
    s0_c_d.dt    = dt;
  end

  // ---------------------------------------------------------- divider stages
  logic [DN-1:0]  dv_v_q;
  logic [DW:0]    dv_r_q [DN];
  logic [DW:0]    dv_r_d [DN];
  logic [UW-1:0]  dv_u_q [DN];
  logic [UW-1:0]  dv_u_d [DN];
  che_pkg::ctx_t  dv_c_q [DN];
  che_pkg::ctx_t  dv_c_d [DN];

  always_comb begin
    logic [DW:0]   tr;
    logic [DW:0]   dtx;
    logic [DW:0]   pr;
    logic [UW-1:0] pu;
    logic          ge;
    for (int k = 0; k < DN; k++) begin
      if (k == 0) begin
        pr        = {1'b0, s0_tau_q};
        pu        = '0;
        dv_c_d[k] = s0_c_q;
        tr        = pr;
      end else begin
        pr        = dv_r_q[k-1];
        pu        = dv_u_q[k-1];
        dv_c_d[k] = dv_c_q[k-1];
        tr        = {pr[DW-1:0], 1'b0};
      end
      dtx       = {1'b0, dv_c_d[k].dt};
      ge        = tr >= dtx;
      dv_r_d[k] = ge ? (tr - dtx) : tr;
      dv_u_d[k] = {pu[UW-2:0], ge};
    end
  end

  logic [UW-1:0] u_w;
  assign u_w = dv_u_q[DN-1];

  // --------------------------------------------------------- M1: u squared
  logic               m1_v_q;
  logic [UW-1:0]      m1_u_q;
  logic [2*UW-1:0]    m1_sq_q;
  che_pkg::ctx_t      m1_c_q;

  // ----------------------------------------------------------- M2: u cubed
  logic               m2_v_q;
  logic [UW-1:0]      m2_u_q;
  logic [UW-1:0]      m2_u2_q;
  logic [2*UW-1:0]    m2_cu_q;
  che_pkg::ctx_t      m2_c_q;
  logic [UW-1:0]      u2_w;
  assign u2_w = m1_sq_q[F +: UW];

  // ---------------------------------------------------------- M3: basis
  logic                 m3_v_q;
  logic signed [HW-1:0] m3_h01_q, m3_h10_q, m3_h11_q;
  logic signed [HW-1:0] h01_d, h10_d, h11_d;
  che_pkg::ctx_t        m3_c_q;

  always_comb begin
    logic signed [HW-1:0] ue, u2e, u3e;
    ue    = signed'({{(HW-UW){1'b0}}, m2_u_q});
    u2e   = signed'({{(HW-UW){1'b0}}, m2_u2_q});
    u3e   = signed'({{(HW-UW){1'b0}}, m2_cu_q[F +: UW]});
    h01_d = (u2e <<< 1) + u2e - (u3e <<< 1);
    h10_d = u3e - (u2e <<< 1) + ue;
    h11_d = u3e - u2e;
  end

  // ------------------------------------------------- M4: weight products
  logic                                m4_v_q;
  logic signed [che_pkg::P01_W-1:0]    m4_p01_q;
  logic signed [che_pkg::P1X_W-1:0]    m4_p10_q, m4_p11_q;
  che_pkg::ctx_t                       m4_c_q;
  logic signed [DW:0]                  dts_w;
  assign dts_w = signed'({1'b0, m3_c_q.dt});

  // ----------------------------------------------- M5: velocity products
  logic                                m5_v_q;
  logic signed [che_pkg::PV_W-1:0]     m5_pv10_q, m5_pv11_q;
  logic signed [che_pkg::T01_W-1:0]    m5_t01_q;
  che_pkg::ctx_t                       m5_c_q;
  logic signed [DW-1:0]                w10_w, w11_w;
  assign w10_w = signed'(m4_p10_q[F +: DW]);
  assign w11_w = signed'(m4_p11_q[F +: DW]);

  // --------------------------------------------------------------- M6: sum
  logic                 m6_v_q;
  logic signed [SW-1:0] m6_sum_q, sum_d;
  che_pkg::ctx_t        m6_c_q;

  always_comb begin
    logic signed [che_pkg::PVS_W-1:0] a10, a11;
    a10   = signed'(m5_pv10_q[che_pkg::PV_W-1:F]);
    a11   = signed'(m5_pv11_q[che_pkg::PV_W-1:F]);
    sum_d = {{(SW-DW){m5_c_q.ps[DW-1]}}, m5_c_q.ps}
          + {{(SW-che_pkg::T01_W){m5_t01_q[che_pkg::T01_W-1]}}, m5_t01_q}
          + {{(SW-che_pkg::PVS_W){a10[che_pkg::PVS_W-1]}}, a10}
          + {{(SW-che_pkg::PVS_W){a11[che_pkg::PVS_W-1]}}, a11};
  end

  // ---------------------------------------------------- M7: saturate, out
  logic signed [DW-1:0] pos_q, pos_d;
  che_pkg::status_e     st_q, st_d;
  logic                 done_q;

  always_comb begin
    logic hi, lo;
    hi = !m6_sum_q[SW-1] && (|m6_sum_q[SW-2:DW-1]);
    lo = m6_sum_q[SW-1] && !(&m6_sum_q[SW-2:DW-1]);
    if (m6_c_q.empty) begin
      pos_d = m6_c_q.ps;
      st_d  = che_pkg::ST_EMPTY;
    end else if (hi) begin
      pos_d = {1'b0, {(DW-1){1'b1}}};
      st_d  = che_pkg::ST_SAT;
    end else if (lo) begin
      pos_d = {1'b1, {(DW-1){1'b0}}};
      st_d  = che_pkg::ST_SAT;
    end else begin
      pos_d = m6_sum_q[DW-1:0];
      st_d  = m6_c_q.clamp ? che_pkg::ST_CLAMPED : che_pkg::ST_OK;
    end
  end

  // ------------------------------------------------------------ valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      dv_v_q <= '0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      m5_v_q <= 1'b0;
      m6_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s0_v_q <= accept;
      dv_v_q <= {dv_v_q[DN-2:0], s0_v_q};
      m1_v_q <= dv_v_q[DN-1];
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
      m5_v_q <= m4_v_q;
      m6_v_q <= m5_v_q;
      done_q <= m6_v_q;
    end
  end

  // ---------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    s0_tau_q <= s0_tau_d;
    s0_c_q   <= s0_c_d;
    for (int k = 0; k < DN; k++) begin
      dv_r_q[k] <= dv_r_d[k];
      dv_u_q[k] <= dv_u_d[k];
      dv_c_q[k] <= dv_c_d[k];
    end
    m1_u_q    <= u_w;
    m1_sq_q   <= u_w * u_w;
    m1_c_q    <= dv_c_q[DN-1];
    m2_u_q    <= m1_u_q;
    m2_u2_q   <= u2_w;
    m2_cu_q   <= u2_w * m1_u_q;
    m2_c_q    <= m1_c_q;
    m3_h01_q  <= h01_d;
    m3_h10_q  <= h10_d;
    m3_h11_q  <= h11_d;
    m3_c_q    <= m2_c_q;
    m4_p01_q  <= m3_c_q.dp * m3_h01_q;
    m4_p10_q  <= dts_w * m3_h10_q;
    m4_p11_q  <= dts_w * m3_h11_q;
    m4_c_q    <= m3_c_q;
    m5_pv10_q <= w10_w * m4_c_q.vs;
    m5_pv11_q <= w11_w * m4_c_q.vf;
    m5_t01_q  <= signed'(m4_p01_q[che_pkg::P01_W-1:F]);
    m5_c_q    <= m4_c_q;
    m6_sum_q  <= sum_d;
    m6_c_q    <= m5_c_q;
    pos_q     <= pos_d;
    st_q      <= st_d;
  end

  assign done_o     = done_q;
  assign position_o = pos_q;
  assign status_o   = st_q;

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe missing after accepted beat");

  a_sat_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == che_pkg::ST_SAT) |->
      (position_o == {1'b0, {(DW-1){1'b1}}} || position_o == {1'b1, {(DW-1){1'b0}}}))
    else $error("saturated result not at a bound");

  a_u_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DN-1] && !dv_c_q[DN-1].empty) |-> !(u_w[UW-1] && (|u_w[UW-2:0])))
    else $error("divider quotient above one");
`endif

endmodule

`default_nettype wire

>>> bench/che_position_monitor.sv
// Watches both channels of the cubic Hermite evaluator, predicts each result
// beat from the accepted segment beat and compares it field by field.
// Depends on che_pkg.
module che_position_monitor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic signed [che_pkg::DATA_W-1:0] pos_start_i,
  input  logic signed [che_pkg::DATA_W-1:0] pos_end_i,
  input  logic signed [che_pkg::DATA_W-1:0] vel_start_i,
  input  logic signed [che_pkg::DATA_W-1:0] vel_end_i,
  input  logic        [che_pkg::DATA_W-1:0] time_now_i,
  input  logic        [che_pkg::DATA_W-1:0] time_start_i,
  input  logic        [che_pkg::DATA_W-1:0] time_end_i,
  input  logic                              done_i,
  input  logic signed [che_pkg::DATA_W-1:0] position_i,
  input  logic        [1:0]                 status_i,
  output int                                errors_o,
  output int                                pending_o,
  output logic [3:0][31:0]                  status_hits_o
);

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [che_pkg::DATA_W-1:0] position;
    che_pkg::status_e                  status;
  } axis_sample_t;

  axis_sample_t     expected_samples[$];
  axis_sample_t     want;
  int               mismatches = 0;
  int               beats_checked = 0;
  logic [3:0][31:0] hits = '0;

  function automatic axis_sample_t hermite_position(
    input logic signed [che_pkg::DATA_W-1:0] ps, pe, vs, vf,
    input logic        [che_pkg::DATA_W-1:0] tn, ts, te
  );
    axis_sample_t      res;
    longint unsigned   t_eff, span, tau, u, u2, u3;
    longint            h01, h10, h11, w10, w11, dp, acc;
    res.status = che_pkg::ST_OK;
    if (te <= ts) begin
      res.position = ps;
      res.status   = che_pkg::ST_EMPTY;
      return res;
    end
    t_eff = tn;
    if (tn < ts) begin
      t_eff      = ts;
      res.status = che_pkg::ST_CLAMPED;
    end else if (tn > te) begin
      t_eff      = te;
      res.status = che_pkg::ST_CLAMPED;
    end
    span = longint'(te) - longint'(ts);
    tau  = t_eff - longint'(ts);
    u    = (tau << che_pkg::FRAC_BITS) / span;
    u2   = (u * u) >> che_pkg::FRAC_BITS;
    u3   = (u2 * u) >> che_pkg::FRAC_BITS;
    h01  = 3 * longint'(u2) - 2 * longint'(u3);
    h10  = longint'(u3) - 2 * longint'(u2) + longint'(u);
    h11  = longint'(u3) - longint'(u2);
    w10  = (longint'(span) * h10) >>> che_pkg::FRAC_BITS;
    w11  = (longint'(span) * h11) >>> che_pkg::FRAC_BITS;
    dp   = longint'(pe) - longint'(ps);
    acc  = longint'(ps) + ((dp * h01) >>> che_pkg::FRAC_BITS)
         + ((w10 * longint'(vs)) >>> che_pkg::FRAC_BITS)
         + ((w11 * longint'(vf)) >>> che_pkg::FRAC_BITS);
    if (acc > POS_MAX) begin
      acc        = POS_MAX;
      res.status = che_pkg::ST_SAT;
    end else if (acc < POS_MIN) begin
      acc        = POS_MIN;
      res.status = che_pkg::ST_SAT;
    end
    res.position = acc[che_pkg::DATA_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      errors_o      <= 0;
      pending_o     <= 0;
      status_hits_o <= '0;
    end else begin
      if (start_i && !busy_i)
        expected_samples.push_back(hermite_position(pos_start_i, pos_end_i, vel_start_i,
                                                    vel_end_i, time_now_i, time_start_i,
                                                    time_end_i));
      if (done_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, position %h status %0d",
                                    position_i, status_i));
        end else begin
          want = expected_samples.pop_front();
          beats_checked++;
          hits[want.status] = hits[want.status] + 1;
          if (position_i !== want.position)
            report_mismatch($sformatf("beat %0d position %h, expected %h",
                                      beats_checked, position_i, want.position));
          if (status_i !== want.status)
            report_mismatch($sformatf("beat %0d status %0d, expected %s",
                                      beats_checked, status_i, want.status.name()));
        end
      end
      errors_o      <= mismatches;
      pending_o     <= expected_samples.size();
      status_hits_o <= hits;
    end
  end

endmodule

>>> bench/cubic_hermite_point_eval_top_tb.sv
// Top of the cubic Hermite evaluator bench: clock, reset, segment stimulus and
// verdict. Depends on che_pkg, cubic_hermite_point_eval_top and che_position_monitor.
module cubic_hermite_point_eval_top_tb;

  localparam int WATCHDOG_CYCLES = 4000;

  logic                              clk_i        = 1'b0;
  logic                              rst_ni       = 1'b0;
  logic                              start_i      = 1'b0;
  logic signed [che_pkg::DATA_W-1:0] pos_start_i  = '0;
  logic signed [che_pkg::DATA_W-1:0] pos_end_i    = '0;
  logic signed [che_pkg::DATA_W-1:0] vel_start_i  = '0;
  logic signed [che_pkg::DATA_W-1:0] vel_end_i    = '0;
  logic        [che_pkg::DATA_W-1:0] time_now_i   = '0;
  logic        [che_pkg::DATA_W-1:0] time_start_i = '0;
  logic        [che_pkg::DATA_W-1:0] time_end_i   = '0;
  logic                              busy_o;
  logic                              done_o;
  logic signed [che_pkg::DATA_W-1:0] position_o;
  logic        [1:0]                 status_o;

  int               errors;
  int               pending;
  logic [3:0][31:0] status_hits;
  int               idle_pct   = 0;
  int               beats_sent = 0;
  int               n_directed = 0;
  int               quiet      = 0;

  cubic_hermite_point_eval_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .pos_start_i  (pos_start_i),
    .pos_end_i    (pos_end_i),
    .vel_start_i  (vel_start_i),
    .vel_end_i    (vel_end_i),
    .time_now_i   (time_now_i),
    .time_start_i (time_start_i),
    .time_end_i   (time_end_i),
    .done_o       (done_o),
    .position_o   (position_o),
    .status_o     (status_o)
  );

  che_position_monitor u_position_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .pos_start_i   (pos_start_i),
    .pos_end_i     (pos_end_i),
    .vel_start_i   (vel_start_i),
    .vel_end_i     (vel_end_i),
    .time_now_i    (time_now_i),
    .time_start_i  (time_start_i),
    .time_end_i    (time_end_i),
    .done_i        (done_o),
    .position_i    (position_o),
    .status_i      (status_o),
    .errors_o      (errors),
    .pending_o     (pending),
    .status_hits_o (status_hits)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_CYCLES) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending", quiet, pending);
      $display("[cubic_hermite_point_eval_top] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // random magnitude so that small, mid and full-range values all appear
  function automatic logic signed [che_pkg::DATA_W-1:0] rand_mag();
    logic signed [che_pkg::DATA_W-1:0] v;
    v = $urandom;
    return v >>> $urandom_range(31, 0);
  endfunction

  task automatic send_axis(
    input logic signed [che_pkg::DATA_W-1:0] ps, pe, vs, vf,
    input logic        [che_pkg::DATA_W-1:0] tn, ts, te
  );
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    pos_start_i  <= ps;
    pos_end_i    <= pe;
    vel_start_i  <= vs;
    vel_end_i    <= vf;
    time_now_i   <= tn;
    time_start_i <= ts;
    time_end_i   <= te;
    start_i      <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // mostly well-formed segments, then clamped times, empty segments and noise
  task automatic send_random_axis();
    logic [che_pkg::DATA_W-1:0] ts, te, tn, span, room;
    int                         kind;
    kind = $urandom_range(99, 0);
    ts   = $urandom;
    if (ts == '1) ts = ts - 1;
    room = 32'hFFFF_FFFF - ts;
    if ($urandom_range(1, 0)) span = $urandom_range((room < 4096) ? room : 4096, 1);
    else                      span = $urandom_range(room, 1);
    te = ts + span;
    tn = ts + $urandom_range(span, 0);
    if (kind >= 65 && kind < 80) begin
      if (te != '1 && ($urandom_range(1, 0) || ts == 0)) tn = $urandom_range(32'hFFFF_FFFF, te + 1);
      else if (ts != 0)                                   tn = $urandom_range(ts - 1, 0);
    end else if (kind >= 80 && kind < 90) begin
      te = $urandom_range(ts, 0);
      tn = $urandom;
    end else if (kind >= 90) begin
      ts = $urandom;
      te = $urandom;
      tn = $urandom;
    end
    send_axis(rand_mag(), rand_mag(), rand_mag(), rand_mag(), tn, ts, te);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty segments, segment ends, clamping, extremes, saturation
    send_axis('0, '0, '0, '0, '0, '0, '0);
    send_axis(32'sh8000_0000, 32'sh7FFF_FFFF, '0, '0, 32'd70, 32'd100, 32'd50);
    send_axis(32'sh0001_0000, 32'sh0005_0000, 32'sh0000_8000, -32'sh0000_8000,
              32'h0, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh0001_0000, 32'sh0005_0000, 32'sh0000_8000, -32'sh0000_8000,
              32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh0001_0000, 32'sh0005_0000, 32'sh0000_8000, -32'sh0000_8000,
              32'h0002_0000, 32'h0001_0000, 32'h0003_0000);
    send_axis(32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000,
              32'h0, 32'h0000_1000, 32'h0010_0000);
    send_axis(32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000,
              32'hFFFF_FFFF, 32'h0000_1000, 32'hFFFF_FFFE);
    send_axis(32'sh8000_0000, 32'sh7FFF_FFFF, '0, '0,
              32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh7FFF_FFFF, 32'sh8000_0000, '0, '0,
              32'h4000_0000, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0,
              32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0,
              32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh8000_0000, 32'sh8000_0000, '0, 32'sh7FFF_FFFF,
              32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, 32'sh8000_0000,
              32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh0000_1234, 32'sh0010_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'd5, 32'd5, 32'd6);
    send_axis(32'sh0000_1234, 32'sh0010_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'd6, 32'd5, 32'd6);
    send_axis('1, '1, '1, '1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_axis(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_axis(32'sh4000_0000, -32'sh4000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'hC000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    n_directed = beats_sent;

    idle_pct = 0;
    repeat (250) send_random_axis();
    idle_pct = 85;
    repeat (150) send_random_axis();
    idle_pct = 22;
    repeat (250) send_random_axis();
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (che_pkg::LATENCY + 8) @(posedge clk_i);

    $display("Summary: %0d axis beats sent, %0d directed, the rest random over three idling phases",
             beats_sent, n_directed);
    $display("Summary: results ok %0d, clamped %0d, empty %0d, saturated %0d",
             status_hits[che_pkg::ST_OK], status_hits[che_pkg::ST_CLAMPED],
             status_hits[che_pkg::ST_EMPTY], status_hits[che_pkg::ST_SAT]);
    if (errors == 0) begin
      $display("[cubic_hermite_point_eval_top] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[cubic_hermite_point_eval_top] ERROR");
    end
    $finish;
  end

endmodule
